// ===== design/assert_macros.svh =====
// Assertion macros shared by the timestamp validator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while rst is high.
`define TSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge of clk, reset cycles included.
`define TSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSV_ASSERT(lbl, prop, msg)
`define TSV_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== design/tsv_pkg.sv =====
// Types, phase codes and character helpers for the timestamp validator.
package tsv_pkg;

  // Grammar position, one-hot coded.
  typedef enum logic [22:0] {
    PH_LEAD   = 23'h000001,
    PH_Y1     = 23'h000002,
    PH_Y2     = 23'h000004,
    PH_Y3     = 23'h000008,
    PH_DASH1  = 23'h000010,
    PH_M0     = 23'h000020,
    PH_M1     = 23'h000040,
    PH_DASH2  = 23'h000080,
    PH_D0     = 23'h000100,
    PH_D1     = 23'h000200,
    PH_SEP    = 23'h000400,
    PH_TWS    = 23'h000800,
    PH_H1     = 23'h001000,
    PH_COLON1 = 23'h002000,
    PH_MI0    = 23'h004000,
    PH_MI1    = 23'h008000,
    PH_AFTMIN = 23'h010000,
    PH_S0     = 23'h020000,
    PH_S1     = 23'h040000,
    PH_AFTSEC = 23'h080000,
    PH_FRAC0  = 23'h100000,
    PH_FRAC   = 23'h200000,
    PH_TRAIL  = 23'h400000
  } phase_t;

  // Character codes used by the grammar.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;

  // Limits of the time fields.
  localparam logic [4:0] MAX_HOUR       = 5'd23;
  localparam logic [3:0] MAX_MINUTE_TEN = 4'd5;

  // One byte handed from the input stage to the parser.
  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] char_code;
  } step_t;

  // Space and the control codes 9 to 13.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // ASCII decimal digit.
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // A two-digit number (tens, ones) is a multiple of four.
  function automatic logic div4_2dig(input logic [3:0] tens, input logic [3:0] ones);
    logic ones_even_set;
    logic ones_odd_set;
    ones_even_set = (ones == 4'd0) || (ones == 4'd4) || (ones == 4'd8);
    ones_odd_set  = (ones == 4'd2) || (ones == 4'd6);
    return tens[0] ? ones_odd_set : ones_even_set;
  endfunction

  // Gregorian leap rule on a year given as four decimal digits.
  function automatic logic is_leap(input logic [3:0] d0, input logic [3:0] d1,
                                   input logic [3:0] d2, input logic [3:0] d3);
    logic low_zero;
    low_zero = (d2 == 4'd0) && (d3 == 4'd0);
    return low_zero ? div4_2dig(d0, d1) : div4_2dig(d2, d3);
  endfunction

  // Length of a month in a common year.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/tsv_parser.sv =====
// Grammar state machine and field checks of the timestamp validator.
`include "assert_macros.svh"

module tsv_parser (
  input  logic          clk,
  input  logic          rst,
  input  tsv_pkg::step_t st,
  output logic          verdict
);
  import tsv_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  phase_t     phase_adv;
  logic       failed;
  logic       failed_next;
  logic       adv_ok;

  logic [3:0] year_d0, year_d1, year_d2, year_d3;
  logic [3:0] month_value;
  logic [3:0] day_tens;
  logic [3:0] hour_tens;

  logic       ch_ws;
  logic       ch_dg;
  logic [3:0] ch_d;
  logic [6:0] day_num;
  logic [4:0] day_max;
  logic [6:0] hour_num;
  logic [6:0] month_num;
  logic       load_en;

  // Byte classification.
  assign ch_ws = is_ws(st.char_code);
  assign ch_dg = is_digit(st.char_code);
  assign ch_d  = ch_dg ? st.char_code[3:0] : 4'd0;

  // Two-digit field values.
  assign month_num = 7'(month_value) * 7'd10 + 7'(ch_d);
  assign day_num   = 7'(day_tens) * 7'd10 + 7'(ch_d);
  assign hour_num  = 7'(hour_tens) * 7'd10 + 7'(ch_d);

  // Upper bound of the day, February lengthened in leap years.
  always_comb begin
    day_max = month_days(month_value);
    if (month_value == 4'd2 && is_leap(year_d0, year_d1, year_d2, year_d3)) begin
      day_max = 5'd29;
    end
  end

  // One step through the grammar for the current byte.
  always_comb begin
    phase_adv = phase;
    adv_ok    = 1'b1;
    unique case (phase)
      PH_LEAD: begin
        if (!ch_ws) begin
          adv_ok    = ch_dg;
          phase_adv = PH_Y1;
        end
      end
      PH_Y1: begin
        adv_ok    = ch_dg;
        phase_adv = PH_Y2;
      end
      PH_Y2: begin
        adv_ok    = ch_dg;
        phase_adv = PH_Y3;
      end
      PH_Y3: begin
        adv_ok    = ch_dg;
        phase_adv = PH_DASH1;
      end
      PH_DASH1: begin
        adv_ok    = (st.char_code == CH_DASH);
        phase_adv = PH_M0;
      end
      PH_M0: begin
        adv_ok    = ch_dg;
        phase_adv = PH_M1;
      end
      PH_M1: begin
        adv_ok    = ch_dg && (month_num >= 7'd1) && (month_num <= 7'd12);
        phase_adv = PH_DASH2;
      end
      PH_DASH2: begin
        adv_ok    = (st.char_code == CH_DASH);
        phase_adv = PH_D0;
      end
      PH_D0: begin
        adv_ok    = ch_dg;
        phase_adv = PH_D1;
      end
      PH_D1: begin
        adv_ok    = ch_dg && (day_num >= 7'd1) && (day_num <= 7'(day_max));
        phase_adv = PH_SEP;
      end
      PH_SEP: begin
        if (st.char_code == CH_SPACE || st.char_code == CH_T) begin
          phase_adv = PH_TWS;
        end else begin
          adv_ok = ch_ws;
        end
      end
      PH_TWS: begin
        if (!ch_ws) begin
          adv_ok    = ch_dg;
          phase_adv = PH_H1;
        end
      end
      PH_H1: begin
        adv_ok    = ch_dg && (hour_num <= 7'(MAX_HOUR));
        phase_adv = PH_COLON1;
      end
      PH_COLON1: begin
        adv_ok    = (st.char_code == CH_COLON);
        phase_adv = PH_MI0;
      end
      PH_MI0: begin
        adv_ok    = ch_dg && (ch_d <= MAX_MINUTE_TEN);
        phase_adv = PH_MI1;
      end
      PH_MI1: begin
        adv_ok    = ch_dg;
        phase_adv = PH_AFTMIN;
      end
      PH_AFTMIN: begin
        if (st.char_code == CH_COLON) begin
          phase_adv = PH_S0;
        end else begin
          adv_ok    = ch_ws;
          phase_adv = PH_TRAIL;
        end
      end
      PH_S0: begin
        adv_ok    = ch_dg && (ch_d <= MAX_MINUTE_TEN);
        phase_adv = PH_S1;
      end
      PH_S1: begin
        adv_ok    = ch_dg;
        phase_adv = PH_AFTSEC;
      end
      PH_AFTSEC: begin
        if (st.char_code == CH_DOT) begin
          phase_adv = PH_FRAC0;
        end else begin
          adv_ok    = ch_ws;
          phase_adv = PH_TRAIL;
        end
      end
      PH_FRAC0: begin
        adv_ok    = ch_dg;
        phase_adv = PH_FRAC;
      end
      PH_FRAC: begin
        if (!ch_dg) begin
          adv_ok    = ch_ws;
          phase_adv = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        adv_ok = ch_ws;
      end
      default: begin
        adv_ok = 1'b0;
      end
    endcase
  end

  // The verdict for a last byte, taken from the state the byte leaves behind.
  assign verdict = !failed && adv_ok &&
                   (phase_adv == PH_AFTMIN || phase_adv == PH_AFTSEC ||
                    phase_adv == PH_FRAC || phase_adv == PH_TRAIL);

  // Control state: a last byte returns the parser to its starting point.
  always_comb begin
    phase_next  = phase;
    failed_next = failed;
    if (st.step) begin
      if (st.last) begin
        phase_next  = PH_LEAD;
        failed_next = 1'b0;
      end else if (!failed) begin
        phase_next  = phase_adv;
        failed_next = !adv_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LEAD;
      failed <= 1'b0;
    end else begin
      phase  <= phase_next;
      failed <= failed_next;
    end
  end

  // Field digits, captured as the grammar reaches them.
  assign load_en = st.step && !failed;

  always_ff @(posedge clk) begin
    if (load_en) begin
      if (phase == PH_LEAD) year_d0 <= ch_d;
      if (phase == PH_Y1) year_d1 <= ch_d;
      if (phase == PH_Y2) year_d2 <= ch_d;
      if (phase == PH_Y3) year_d3 <= ch_d;
      if (phase == PH_M0) month_value <= ch_d;
      if (phase == PH_M1) month_value <= month_num[3:0];
      if (phase == PH_D0) day_tens <= ch_d;
      if (phase == PH_TWS) hour_tens <= ch_d;
    end
  end

  // A last byte always leaves a fresh parser behind.
  `TSV_ASSERT(a_last_clears, st.step && st.last |=> phase == PH_LEAD && !failed, "parser not cleared after last byte")
  // A rejection sticks until the string ends.
  `TSV_ASSERT(a_fail_sticky, failed && !(st.step && st.last) |=> failed, "rejection lost before end of string")
  // Without a byte the grammar position does not move.
  `TSV_ASSERT(a_idle_hold, !st.step |=> $stable(phase) && $stable(failed), "parser moved without a byte")

endmodule

// ===== design/timestamp_text_validator_core.sv =====
// Top level of the timestamp validator: input stage, parser and result register.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------
//   input    | char_valid / char_ready     | char_byte, is_last
//   result   | result_valid / result_ready | is_valid
//
// One byte is taken per cycle unless a last byte is held in the input register,
// where the parser's next-state logic decides each byte; a verdict appears in the
// result register on the cycle after its last byte leaves the input register.
// The input register keeps the pipeline full while a verdict waits to be taken;
// only a last byte waits on a full, stalled result register.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the start of the grammar.
`include "assert_macros.svh"

module timestamp_text_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_byte,
  input  logic       is_last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       is_valid
);
  import tsv_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_adv;
  logic       out_free;
  logic       verdict;
  step_t      st;

  // A byte leaves the input register unless it is a last byte facing a full result.
  assign out_free   = !result_valid || result_ready;
  assign s1_adv     = s1_valid && (!s1_last || out_free);
  assign char_ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      s1_char <= char_byte;
      s1_last <= is_last;
    end
  end

  // Parser.
  assign st.step      = s1_adv;
  assign st.last      = s1_last;
  assign st.char_code = s1_char;

  tsv_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .st      (st),
    .verdict (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      is_valid <= verdict;
    end
  end

  // A new verdict only follows a last byte leaving the input stage.
  `TSV_ASSERT(a_result_source, $rose(result_valid) |-> $past(s1_adv && s1_last), "verdict without a last byte")
  // A held byte in the input register is not overwritten.
  `TSV_ASSERT(a_s1_hold, s1_valid && !s1_adv |=> s1_valid && $stable(s1_char) && $stable(s1_last), "input byte lost")
  // Reset empties both stages.
  `TSV_ASSERT_RST(a_reset_empty, rst |=> !s1_valid && !result_valid, "pipeline not empty after reset")

endmodule

// ===== dv/tsv_verdict_checker.sv =====
// Checker for the timestamp validator: follows the grammar on accepted bytes and compares verdicts.
module tsv_verdict_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [7:0] char_byte,
  input  logic       is_last,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic       is_valid,
  output int         mismatches,
  output int         verdicts_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsv_pkg::*;

  // Shadow copy of the parser state.
  phase_t      phase;
  logic [13:0] year_acc;
  logic [3:0]  month_acc;
  logic [3:0]  day_hi;
  logic [3:0]  hour_hi;
  logic        rejected;

  // Verdicts predicted but not yet delivered, oldest first.
  logic        verdict_q[$];

  initial begin
    mismatches       = 0;
    verdicts_waiting = 0;
  end

  function automatic logic blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Days in a month, February following the Gregorian leap rule.
  function automatic int days_in(input logic [13:0] y, input logic [3:0] m);
    int len;
    case (m)
      4'd2:                    len = 28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      default:                 len = 31;
    endcase
    if (m == 4'd2 && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0)) begin
      len = 29;
    end
    return len;
  endfunction

  task automatic restart_grammar();
    phase     = PH_LEAD;
    year_acc  = '0;
    month_acc = '0;
    day_hi    = '0;
    hour_hi   = '0;
    rejected  = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Advance the grammar by one byte and predict a verdict on the last one.
  task automatic take_byte(input logic [7:0] c, input logic last);
    logic       ok;
    logic       dig;
    logic [3:0] d;
    int         num;
    logic       good;
    dig = numeral(c);
    d   = dig ? 4'(c - 8'h30) : 4'd0;
    ok  = 1'b1;
    if (!rejected) begin
      case (phase)
        PH_LEAD: begin
          if (!blank(c)) begin
            if (!dig) ok = 1'b0;
            else begin
              year_acc = 14'(d);
              phase    = PH_Y1;
            end
          end
        end
        PH_Y1, PH_Y2, PH_Y3: begin
          if (!dig) ok = 1'b0;
          else begin
            year_acc = 14'(year_acc * 10 + d);
            phase    = (phase == PH_Y1) ? PH_Y2 : (phase == PH_Y2) ? PH_Y3 : PH_DASH1;
          end
        end
        PH_DASH1: begin
          if (c != CH_DASH) ok = 1'b0;
          else phase = PH_M0;
        end
        PH_M0: begin
          if (!dig) ok = 1'b0;
          else begin
            month_acc = d;
            phase     = PH_M1;
          end
        end
        PH_M1: begin
          num = month_acc * 10 + d;
          if (!dig || num < 1 || num > 12) ok = 1'b0;
          else begin
            month_acc = 4'(num);
            phase     = PH_DASH2;
          end
        end
        PH_DASH2: begin
          if (c != CH_DASH) ok = 1'b0;
          else phase = PH_D0;
        end
        PH_D0: begin
          if (!dig) ok = 1'b0;
          else begin
            day_hi = d;
            phase  = PH_D1;
          end
        end
        PH_D1: begin
          num = day_hi * 10 + d;
          if (!dig || num < 1 || num > days_in(year_acc, month_acc)) ok = 1'b0;
          else phase = PH_SEP;
        end
        PH_SEP: begin
          if (c == CH_SPACE || c == CH_T) phase = PH_TWS;
          else ok = blank(c);
        end
        PH_TWS: begin
          if (!blank(c)) begin
            if (!dig) ok = 1'b0;
            else begin
              hour_hi = d;
              phase   = PH_H1;
            end
          end
        end
        PH_H1: begin
          if (!dig || hour_hi * 10 + d > 23) ok = 1'b0;
          else phase = PH_COLON1;
        end
        PH_COLON1: begin
          if (c != CH_COLON) ok = 1'b0;
          else phase = PH_MI0;
        end
        PH_MI0: begin
          if (!dig || d > 4'd5) ok = 1'b0;
          else phase = PH_MI1;
        end
        PH_MI1: begin
          if (!dig) ok = 1'b0;
          else phase = PH_AFTMIN;
        end
        PH_AFTMIN: begin
          if (c == CH_COLON) phase = PH_S0;
          else if (blank(c)) phase = PH_TRAIL;
          else ok = 1'b0;
        end
        PH_S0: begin
          if (!dig || d > 4'd5) ok = 1'b0;
          else phase = PH_S1;
        end
        PH_S1: begin
          if (!dig) ok = 1'b0;
          else phase = PH_AFTSEC;
        end
        PH_AFTSEC: begin
          if (c == CH_DOT) phase = PH_FRAC0;
          else if (blank(c)) phase = PH_TRAIL;
          else ok = 1'b0;
        end
        PH_FRAC0: begin
          if (!dig) ok = 1'b0;
          else phase = PH_FRAC;
        end
        PH_FRAC: begin
          if (!dig) begin
            if (blank(c)) phase = PH_TRAIL;
            else ok = 1'b0;
          end
        end
        PH_TRAIL: ok = blank(c);
        default:  ok = 1'b0;
      endcase
      if (!ok) rejected = 1'b1;
    end
    if (last) begin
      good = !rejected && (phase == PH_AFTMIN || phase == PH_AFTSEC ||
                           phase == PH_FRAC || phase == PH_TRAIL);
      verdict_q = {verdict_q, good};
      restart_grammar();
    end
  endtask

  // Compare delivered verdicts first, then fold in the byte of this edge.
  always @(posedge clk) begin
    logic wanted;
    if (rst) begin
      restart_grammar();
      verdict_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict delivered with no string pending");
        end else begin
          wanted = verdict_q.pop_front();
          if (is_valid !== wanted) begin
            report_mismatch($sformatf("is_valid is %b, expected %b", is_valid, wanted));
          end
        end
      end
      if (char_valid && char_ready) begin
        take_byte(char_byte, is_last);
      end
    end
    verdicts_waiting = verdict_q.size();
  end

endmodule

// ===== dv/timestamp_text_validator_core_test.sv =====
// Testbench top for the timestamp validator: stimulus, result-side flow control and verdict.
module timestamp_text_validator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsv_pkg::*;

  localparam int BYTE_TARGET  = 1350;
  localparam int QUIET_FROM   = 1150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 120;

  typedef enum int {
    FIELD_OK, FIELD_MONTH, FIELD_DAY, FIELD_HOUR, FIELD_MINUTE, FIELD_SECOND
  } bad_field_t;

  typedef enum int {
    DAMAGE_NONE, DAMAGE_REPLACE, DAMAGE_INSERT, DAMAGE_DROP, DAMAGE_TRUNCATE
  } damage_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid;
  logic       char_ready;
  logic [7:0] char_byte;
  logic       is_last;
  logic       result_valid;
  logic       result_ready;
  logic       is_valid;
  int         mismatches;
  int         verdicts_waiting;

  // Shared between the sender and the result-side process.
  logic       quiet        = 1'b0;
  logic       hold_request = 1'b0;
  int         held_cycles  = 0;

  int         bytes_sent   = 0;
  int         strings_sent = 0;
  int         clean_sent   = 0;
  int         broken_sent  = 0;
  int         noise_sent   = 0;

  logic [7:0] line_buf[$];

  always #5 clk = ~clk;

  timestamp_text_validator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_byte    (char_byte),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_valid     (is_valid)
  );

  tsv_verdict_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .char_valid       (char_valid),
    .char_ready       (char_ready),
    .char_byte        (char_byte),
    .is_last          (is_last),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .is_valid         (is_valid),
    .mismatches       (mismatches),
    .verdicts_waiting (verdicts_waiting)
  );

  // Offer one byte, with an occasional idle burst first, and wait for the transaction.
  task automatic offer_byte(input logic [7:0] c, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_byte  <= c;
    is_last    <= last;
    do @(posedge clk); while (!char_ready);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) begin
      offer_byte(line_buf[i], i == line_buf.size() - 1);
    end
    strings_sent++;
  endtask

  // Add one byte at the end of the line being built.
  task automatic append_byte(input logic [7:0] c);
    line_buf = {line_buf, c};
  endtask

  task automatic load_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      append_byte(s[i]);
    end
  endtask

  task automatic send_text(input string s);
    load_text(s);
    send_line();
  endtask

  task automatic push_number(input int value, input int digits);
    int div;
    div = 1;
    repeat (digits - 1) div *= 10;
    while (div > 0) begin
      append_byte(8'(48 + (value / div) % 10));
      div /= 10;
    end
  endtask

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  // Build a timestamp with random content; one field may be pushed out of range.
  task automatic build_stamp(input bad_field_t bad);
    int year;
    int month;
    int day;
    int form;
    line_buf.delete();
    repeat ($urandom_range(0, 2)) append_byte(random_blank());
    case ($urandom_range(0, 3))
      0:       year = $urandom_range(0, 9999);
      1:       year = 4 * $urandom_range(0, 2499);
      2:       year = 100 * $urandom_range(0, 99);
      default: year = 400 * $urandom_range(0, 24);
    endcase
    month = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
    if (bad == FIELD_MONTH) month = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(13, 99);
    day = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    if (bad == FIELD_DAY) day = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(32, 99);
    push_number(year, 4);
    append_byte(CH_DASH);
    push_number(month, 2);
    append_byte(CH_DASH);
    push_number(day, 2);
    // Control whitespace may come before the separator, never a space.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(9, 13)));
    end
    append_byte($urandom_range(0, 1) ? CH_T : CH_SPACE);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) append_byte(random_blank());
    end
    push_number((bad == FIELD_HOUR) ? $urandom_range(24, 99) : $urandom_range(0, 23), 2);
    append_byte(CH_COLON);
    push_number((bad == FIELD_MINUTE) ? $urandom_range(60, 99) : $urandom_range(0, 59), 2);
    form = $urandom_range(0, 2);
    if (bad == FIELD_SECOND && form == 0) form = 1;
    if (form > 0) begin
      append_byte(CH_COLON);
      push_number((bad == FIELD_SECOND) ? $urandom_range(60, 99) : $urandom_range(0, 59), 2);
    end
    if (form > 1) begin
      append_byte(CH_DOT);
      repeat ($urandom_range(1, 4)) push_number($urandom_range(0, 9), 1);
    end
    repeat ($urandom_range(0, 2)) append_byte(random_blank());
  endtask

  // Break a built string at a random place.
  task automatic damage_line(input damage_t how);
    int pos;
    pos = $urandom_range(0, line_buf.size() - 1);
    case (how)
      DAMAGE_REPLACE:  line_buf[pos] = 8'($urandom_range(0, 255));
      DAMAGE_INSERT:   line_buf.insert(pos, 8'($urandom_range(0, 255)));
      DAMAGE_DROP:     if (line_buf.size() > 1) line_buf.delete(pos);
      DAMAGE_TRUNCATE: repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
      default: ;
    endcase
  endtask

  // Stimulus: reset, directed strings, then random strings.
  initial begin
    int choice;
    char_valid <= 1'b0;
    char_byte  <= 8'h00;
    is_last    <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Year zero counts as leap; widest time form with surrounding whitespace.
    send_text("\0110000-02-29T23:59:59.9 \015");
    send_text("1900-02-29 00:00");
    send_text("2000-02-29\013 \01200:00:00");
    send_text("9999-12-31T00:00");
    send_text("2023-02-29T12:00");
    send_text("2024-02-29T12:00:00.0123456789");
    send_text("2024-13-01T00:00");
    send_text("2024-00-10T00:00");
    send_text("2024-04-31T10:00");
    send_text("2024-01-00T10:00");
    send_text("2024-01-01T24:00");
    send_text("2024-01-01T10:60");
    send_text("2024-01-01T10:00:60");
    // Truncated strings, a fraction with no digits and a stray letter after a fraction.
    send_text("2024-01-01T10:5");
    send_text("2024-01-01T10:00:00.");
    send_text("2024-01-01T10:00:00.12x");
    // Whitespace only, and single bytes at both ends of the range.
    send_text("  \011 ");
    line_buf = '{8'h00};
    send_line();
    line_buf = '{8'hFF};
    send_line();
    // Bytes above 127 inside and after an otherwise good string.
    load_text("2024-01-01T10:00 ");
    line_buf[16] = 8'hA0;
    send_line();
    load_text("2024-01-01T10:00");
    line_buf[3] = 8'hB4;
    send_line();

    // Random part: mostly well-formed timestamps, mixed with broken ones and noise.
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
      if (bytes_sent >= HOLD_AT && held_cycles == 0) hold_request = 1'b1;
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        line_buf.delete();
        repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
        noise_sent++;
      end else if (choice <= 2) begin
        build_stamp(FIELD_OK);
        damage_line(damage_t'($urandom_range(DAMAGE_REPLACE, DAMAGE_TRUNCATE)));
        broken_sent++;
      end else if (choice == 3) begin
        build_stamp(bad_field_t'($urandom_range(FIELD_MONTH, FIELD_SECOND)));
        broken_sent++;
      end else begin
        build_stamp(FIELD_OK);
        clean_sent++;
      end
      send_line();
    end
    char_valid <= 1'b0;

    // Drain: wait for every verdict to be delivered.
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Sent %0d bytes in %0d strings: %0d clean timestamps, %0d broken, %0d noise.",
             bytes_sent, strings_sent, clean_sent, broken_sent, noise_sent);
    $display("Result side was held off once for %0d cycles while input kept coming.",
             held_cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result-side flow control: random stalls, one long hold-off, none near the end.
  initial begin
    result_ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_ready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
        held_cycles  = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== timestamp_text_validator_core.f =====
+incdir+design
design/tsv_pkg.sv
design/tsv_parser.sv
design/timestamp_text_validator_core.sv
dv/tsv_verdict_checker.sv
dv/timestamp_text_validator_core_test.sv
